>>> sv/spritz_sponge_engine_assert.svh
// assertion macros used by the checker of the sponge engine
`ifndef SPRITZ_SPONGE_ENGINE_ASSERT_SVH
`define SPRITZ_SPONGE_ENGINE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define SSE_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent in the same cycle as the antecedent
`define SSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define SSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sse_pkg.sv
package sse_pkg;

    localparam int DATA_W = 8;
    localparam int CMD_W  = 2;

    // command codes carried on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_RESET  = 2'd0,
        CMD_ABSORB = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_DRIP   = 2'd3
    } cmd_t;

    // one input beat as seen by the core
    typedef struct packed {
        cmd_t              command;
        logic [DATA_W-1:0] data;
    } cmd_beat_t;

    // shuffle runs whip, crush, whip, crush, whip: phases 0 to 4
    localparam logic [2:0] SHUF_LAST = 3'd4;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_AB0,
        ST_AB1,
        ST_AB2,
        ST_AB3,
        ST_UP0,
        ST_UP1,
        ST_UP2,
        ST_UP3,
        ST_UP4,
        ST_WSTEP,
        ST_CR0,
        ST_CR1,
        ST_CR2,
        ST_CR3,
        ST_DR0,
        ST_DR1,
        ST_DR2,
        ST_DR3,
        ST_EMIT
    } state_t;

endpackage

>>> sv/sse_core.sv
module sse_core #(
    parameter int PERM_SIZE = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  sse_pkg::cmd_beat_t                cmd,
    output logic                              res_valid,
    output logic [sse_pkg::DATA_W-1:0]        res_byte,
    input  logic                              res_ready
);

    localparam int IW = $clog2(PERM_SIZE);
    localparam int CW = IW + 1;

    localparam logic [CW-1:0] N_C        = CW'(PERM_SIZE);
    localparam logic [CW-1:0] INIT_LAST  = CW'(PERM_SIZE - 1);
    localparam logic [CW-1:0] UPD_LAST   = CW'(2 * PERM_SIZE - 1);
    localparam logic [CW-1:0] CRUSH_LAST = CW'(PERM_SIZE / 2 - 1);
    localparam logic [IW-1:0] HALF_I     = IW'(PERM_SIZE / 2);
    localparam logic [IW-1:0] TOP_I      = IW'(PERM_SIZE - 1);
    localparam logic [IW-1:0] ONE_I      = IW'(1);

    // bit v set when v and the permutation size share no factor
    function automatic logic [PERM_SIZE-1:0] coprime_map();
        logic [PERM_SIZE-1:0] m;
        int                   x;
        int                   y;
        m = '0;
        for (int v = 0; v < PERM_SIZE; v++) begin
            x = v;
            y = PERM_SIZE;
            while (x != 0 && y != 0) begin
                if (x >= y) begin
                    x = x - y;
                end else begin
                    y = y - x;
                end
            end
            m[v] = ((x + y) == 1);
        end
        return m;
    endfunction

    localparam logic [PERM_SIZE-1:0] COPRIME = coprime_map();

    // sum of two indexes modulo the permutation size
    function automatic logic [IW-1:0] mod_add(input logic [IW-1:0] x, input logic [IW-1:0] y);
        logic [CW-1:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= N_C) begin
            s = s - N_C;
        end
        return s[IW-1:0];
    endfunction

    sse_pkg::state_t             state_reg, state_next;
    sse_pkg::cmd_t               cmd_reg, cmd_next;
    logic [sse_pkg::DATA_W-1:0]  data_reg, data_next;
    logic                        nib_hi_reg, nib_hi_next;
    logic [IW-1:0]               i_reg, i_next;
    logic [IW-1:0]               j_reg, j_next;
    logic [IW-1:0]               k_reg, k_next;
    logic [IW-1:0]               z_reg, z_next;
    logic [IW-1:0]               a_reg, a_next;
    logic [IW-1:0]               w_reg, w_next;
    logic [IW-1:0]               ik_reg, ik_next;
    logic [IW-1:0]               tmp_reg, tmp_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [2:0]                  phase_reg, phase_next;

    // permutation store, one write and one read port
    logic [IW-1:0] perm_mem [PERM_SIZE];
    logic [IW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] wr_data;

    logic [3:0]    nib;
    logic [IW-1:0] nib_addr;
    logic [IW-1:0] cr_addr;
    logic [IW-1:0] i_sum;
    logic [IW-1:0] j_sum;
    logic [IW-1:0] w_sum;

    assign nib      = nib_hi_reg ? data_reg[7:4] : data_reg[3:0];
    assign nib_addr = HALF_I + IW'(nib);
    assign cr_addr  = TOP_I - cnt_reg[IW-1:0];
    assign i_sum    = mod_add(i_reg, w_reg);
    assign j_sum    = mod_add(k_reg, rd_data_reg);
    assign w_sum    = mod_add(w_reg, ONE_I);
    assign res_byte = data_reg ^ sse_pkg::DATA_W'(z_reg);

    always_ff @(posedge aclk) begin
        if (we) begin
            perm_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= perm_mem[rd_addr];
    end

    // state register and sponge registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sse_pkg::ST_INIT;
            cmd_reg    <= sse_pkg::CMD_RESET;
            nib_hi_reg <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            z_reg      <= '0;
            a_reg      <= '0;
            w_reg      <= ONE_I;
            cnt_reg    <= '0;
            phase_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            nib_hi_reg <= nib_hi_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            z_reg      <= z_next;
            a_reg      <= a_next;
            w_reg      <= w_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

    // payload holding registers
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        ik_reg   <= ik_next;
        tmp_reg  <= tmp_next;
    end

    // sequencer: next state, memory accesses
    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        nib_hi_next = nib_hi_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        z_next      = z_reg;
        a_next      = a_reg;
        w_next      = w_reg;
        ik_next     = ik_reg;
        tmp_next    = tmp_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        rd_addr     = '0;
        we          = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        cmd_ready   = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            // identity fill, one entry a cycle
            sse_pkg::ST_INIT: begin
                we      = 1'b1;
                wr_addr = cnt_reg[IW-1:0];
                wr_data = cnt_reg[IW-1:0];
                if (cnt_reg == INIT_LAST) begin
                    state_next = sse_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            sse_pkg::ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next    = cmd.command;
                    data_next   = cmd.data;
                    nib_hi_next = 1'b0;
                    if (cmd.command == sse_pkg::CMD_RESET) begin
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        z_next     = '0;
                        a_next     = '0;
                        w_next     = ONE_I;
                        cnt_next   = '0;
                        state_next = sse_pkg::ST_INIT;
                    end else begin
                        state_next = sse_pkg::ST_CHECK;
                    end
                end
            end

            // dispatch, shuffling first where the command needs it
            sse_pkg::ST_CHECK: begin
                unique case (cmd_reg)
                    sse_pkg::CMD_ABSORB: begin
                        if (a_reg == HALF_I) begin
                            phase_next = '0;
                            cnt_next   = '0;
                            state_next = sse_pkg::ST_UP0;
                        end else begin
                            state_next = sse_pkg::ST_AB0;
                        end
                    end
                    sse_pkg::CMD_STOP: begin
                        if (a_reg == HALF_I) begin
                            phase_next = '0;
                            cnt_next   = '0;
                            state_next = sse_pkg::ST_UP0;
                        end else begin
                            a_next     = mod_add(a_reg, ONE_I);
                            state_next = sse_pkg::ST_IDLE;
                        end
                    end
                    sse_pkg::CMD_DRIP: begin
                        phase_next = '0;
                        cnt_next   = '0;
                        state_next = sse_pkg::ST_UP0;
                    end
                    sse_pkg::CMD_RESET: begin
                        state_next = sse_pkg::ST_IDLE;
                    end
                endcase
            end

            // nibble absorb: swap entry a with entry half + nibble
            sse_pkg::ST_AB0: begin
                rd_addr    = a_reg;
                state_next = sse_pkg::ST_AB1;
            end
            sse_pkg::ST_AB1: begin
                tmp_next   = rd_data_reg;
                rd_addr    = nib_addr;
                state_next = sse_pkg::ST_AB2;
            end
            sse_pkg::ST_AB2: begin
                we         = 1'b1;
                wr_addr    = a_reg;
                wr_data    = rd_data_reg;
                state_next = sse_pkg::ST_AB3;
            end
            sse_pkg::ST_AB3: begin
                we      = 1'b1;
                wr_addr = nib_addr;
                wr_data = tmp_reg;
                a_next  = mod_add(a_reg, ONE_I);
                if (nib_hi_reg) begin
                    state_next = sse_pkg::ST_IDLE;
                end else begin
                    nib_hi_next = 1'b1;
                    state_next  = sse_pkg::ST_CHECK;
                end
            end

            // one update: i, j, k, then swap of entries i and j
            sse_pkg::ST_UP0: begin
                i_next     = i_sum;
                rd_addr    = i_sum;
                state_next = sse_pkg::ST_UP1;
            end
            sse_pkg::ST_UP1: begin
                tmp_next   = rd_data_reg;
                rd_addr    = mod_add(j_reg, rd_data_reg);
                ik_next    = mod_add(i_reg, k_reg);
                state_next = sse_pkg::ST_UP2;
            end
            sse_pkg::ST_UP2: begin
                j_next     = j_sum;
                rd_addr    = j_sum;
                state_next = sse_pkg::ST_UP3;
            end
            sse_pkg::ST_UP3: begin
                k_next     = mod_add(ik_reg, rd_data_reg);
                we         = 1'b1;
                wr_addr    = i_reg;
                wr_data    = rd_data_reg;
                state_next = sse_pkg::ST_UP4;
            end
            sse_pkg::ST_UP4: begin
                we      = 1'b1;
                wr_addr = j_reg;
                wr_data = tmp_reg;
                // a drip with nothing absorbed runs a single update
                if (cmd_reg == sse_pkg::CMD_DRIP && a_reg == '0) begin
                    state_next = sse_pkg::ST_DR0;
                end else if (cnt_reg == UPD_LAST) begin
                    state_next = sse_pkg::ST_WSTEP;
                end else begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = sse_pkg::ST_UP0;
                end
            end

            // advance w to the next value coprime to the size
            sse_pkg::ST_WSTEP: begin
                w_next = w_sum;
                if (COPRIME[w_sum]) begin
                    if (phase_reg == sse_pkg::SHUF_LAST) begin
                        a_next     = '0;
                        state_next = sse_pkg::ST_CHECK;
                    end else begin
                        phase_next = phase_reg + 3'd1;
                        cnt_next   = '0;
                        state_next = sse_pkg::ST_CR0;
                    end
                end
            end

            // crush: order the pair v and size-1-v
            sse_pkg::ST_CR0: begin
                rd_addr    = cnt_reg[IW-1:0];
                state_next = sse_pkg::ST_CR1;
            end
            sse_pkg::ST_CR1: begin
                tmp_next   = rd_data_reg;
                rd_addr    = cr_addr;
                state_next = sse_pkg::ST_CR2;
            end
            sse_pkg::ST_CR2: begin
                if (tmp_reg > rd_data_reg) begin
                    we         = 1'b1;
                    wr_addr    = cnt_reg[IW-1:0];
                    wr_data    = rd_data_reg;
                    state_next = sse_pkg::ST_CR3;
                end else if (cnt_reg == CRUSH_LAST) begin
                    phase_next = phase_reg + 3'd1;
                    cnt_next   = '0;
                    state_next = sse_pkg::ST_UP0;
                end else begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = sse_pkg::ST_CR0;
                end
            end
            sse_pkg::ST_CR3: begin
                we      = 1'b1;
                wr_addr = cr_addr;
                wr_data = tmp_reg;
                if (cnt_reg == CRUSH_LAST) begin
                    phase_next = phase_reg + 3'd1;
                    cnt_next   = '0;
                    state_next = sse_pkg::ST_UP0;
                end else begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = sse_pkg::ST_CR0;
                end
            end

            // output byte: three chained lookups
            sse_pkg::ST_DR0: begin
                rd_addr    = mod_add(z_reg, k_reg);
                state_next = sse_pkg::ST_DR1;
            end
            sse_pkg::ST_DR1: begin
                rd_addr    = mod_add(i_reg, rd_data_reg);
                state_next = sse_pkg::ST_DR2;
            end
            sse_pkg::ST_DR2: begin
                rd_addr    = mod_add(j_reg, rd_data_reg);
                state_next = sse_pkg::ST_DR3;
            end
            sse_pkg::ST_DR3: begin
                z_next     = rd_data_reg;
                state_next = sse_pkg::ST_EMIT;
            end

            sse_pkg::ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = sse_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = sse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/spritz_sponge_engine.sv
// channel   dir   beat contents                       handshake
// s_        in    tuser: command, tdata: data         s_tvalid / s_tready
// m_        out   tdata: out_byte (drip only)         m_tvalid / m_tready
//
// One command at a time; the permutation memory has a single read port and
// every access chain runs through it. A shuffle runs three whip passes of
// 2 * PERM_SIZE updates and w steps each, and two crush passes over
// PERM_SIZE / 2 pairs. After aresetn and after a reset command, an identity
// fill of the whole table runs with s_tready low. A result waiting on m_
// does not hold off the next command until the core has another result to
// hand over.
module spritz_sponge_engine #(
    parameter int PERM_SIZE = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] out_byte
);

    sse_pkg::cmd_beat_t         cmd;
    logic                       res_valid;
    logic                       res_ready;
    logic [sse_pkg::DATA_W-1:0] res_byte;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [sse_pkg::DATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign cmd.command = sse_pkg::cmd_t'(s_tuser);
    assign cmd.data    = s_tdata;

    sse_core #(
        .PERM_SIZE(PERM_SIZE)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_byte  (res_byte),
        .res_ready (res_ready)
    );

    // output register between core and m_ side
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res_byte;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/sse_checker.sv
`include "spritz_sponge_engine_assert.svh"

module sse_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic       drip_in;
    logic       beat_out;
    logic [1:0] pend_reg, pend_next;

    assign drip_in  = s_tvalid && s_tready && (s_tuser == sse_pkg::CMD_DRIP);
    assign beat_out = m_tvalid && m_tready;

    // drips accepted whose output beat has not gone out yet
    always_comb begin
        pend_next = pend_reg;
        if (drip_in && !beat_out) begin
            pend_next = pend_reg + 2'd1;
        end else if (beat_out && !drip_in) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `SSE_ASSERT_IMP(a_out_needs_drip, m_tvalid, pend_reg != 2'd0, "output beat without a drip")
    `SSE_ASSERT_IMP(a_two_pending_stall, pend_reg == 2'd2, !s_tready, "third drip taken")
    `SSE_ASSERT_NXT(a_reset_fill, s_tvalid && s_tready && (s_tuser == sse_pkg::CMD_RESET), !s_tready, "no fill after reset command")
    `SSE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output beat changed")

endmodule

bind spritz_sponge_engine sse_checker u_sse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> test/sse_keystream_monitor.sv
`timescale 1ns / 100ps

// watches both channels, tracks the sponge state and checks every output beat
module sse_keystream_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int unsigned fail_cnt,
    output int unsigned pend_cnt,
    output int unsigned byte_cnt,
    output int unsigned shuffle_cnt
);

    localparam int         PERM_N = 256;
    localparam logic [7:0] HALF   = 8'd128;

    // sponge state as the engine should hold it
    logic [7:0] sbox [PERM_N];
    logic [7:0] ri, rj, rk, rz, ra, rw;

    // output bytes still owed by the engine, oldest first
    logic [7:0] keystream_q [$];

    int unsigned fails, shown, bytes_ok, shuffles;

    function automatic void swap_entries(logic [7:0] p, logic [7:0] q);
        logic [7:0] t;
        t       = sbox[p];
        sbox[p] = sbox[q];
        sbox[q] = t;
    endfunction

    function automatic void clear_state();
        for (int n = 0; n < PERM_N; n++) begin
            sbox[n] = 8'(n);
        end
        ri = 8'd0;
        rj = 8'd0;
        rk = 8'd0;
        rz = 8'd0;
        ra = 8'd0;
        rw = 8'd1;
    endfunction

    // update rounds, all index math wraps at 8 bits
    function automatic void spin(int unsigned count);
        logic [7:0] t;
        for (int unsigned n = 0; n < count; n++) begin
            ri = ri + rw;
            t  = rj + sbox[ri];
            rj = rk + sbox[t];
            rk = ri + rk + sbox[rj];
            swap_entries(ri, rj);
        end
    endfunction

    // step must stay coprime to the table size: next odd value
    function automatic void whip_pass();
        spin(2 * PERM_N);
        do begin
            rw = rw + 8'd1;
        end while (rw[0] == 1'b0);
    endfunction

    function automatic void crush_pass();
        logic [7:0] far;
        for (int v = 0; v < PERM_N / 2; v++) begin
            far = 8'(PERM_N - 1 - v);
            if (sbox[v] > sbox[far]) begin
                swap_entries(8'(v), far);
            end
        end
    endfunction

    function automatic void churn();
        whip_pass();
        crush_pass();
        whip_pass();
        crush_pass();
        whip_pass();
        ra = 8'd0;
        shuffles++;
    endfunction

    function automatic void take_nibble(logic [3:0] x);
        if (ra == HALF) begin
            churn();
        end
        swap_entries(ra, {1'b1, 3'b000, x});
        ra = ra + 8'd1;
    endfunction

    // one accepted input beat
    function automatic void apply_beat(sse_pkg::cmd_t c, logic [7:0] d);
        logic [7:0] t;
        case (c)
            sse_pkg::CMD_RESET: begin
                clear_state();
            end
            sse_pkg::CMD_ABSORB: begin
                take_nibble(d[3:0]);
                take_nibble(d[7:4]);
            end
            sse_pkg::CMD_STOP: begin
                if (ra == HALF) begin
                    churn();
                end
                ra = ra + 8'd1;
            end
            default: begin
                if (ra != 8'd0) begin
                    churn();
                end
                spin(1);
                t  = rz + rk;
                t  = ri + sbox[t];
                t  = rj + sbox[t];
                rz = sbox[t];
                keystream_q.push_back(d ^ rz);
            end
        endcase
    endfunction

    function automatic void note_fail(string what, logic [7:0] want, logic [7:0] got);
        fails++;
        if (shown < 10) begin
            $display("[%0t] %s: expected 0x%02h, got 0x%02h", $time, what, want, got);
            shown++;
        end
    endfunction

    always @(posedge aclk) begin
        logic [7:0] want;
        if (!aresetn) begin
            clear_state();
            keystream_q.delete();
            fails    = 0;
            shown    = 0;
            bytes_ok = 0;
            shuffles = 0;
        end else begin
            // output side first: compare against the oldest owed byte
            if (m_tvalid && m_tready) begin
                if (keystream_q.size() == 0) begin
                    note_fail("output beat with nothing pending", 8'h00, m_tdata);
                end else begin
                    want = keystream_q.pop_front();
                    if (m_tdata !== want) begin
                        note_fail("out_byte mismatch", want, m_tdata);
                    end else begin
                        bytes_ok++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_beat(sse_pkg::cmd_t'(s_tuser), s_tdata);
            end
        end
        fail_cnt    <= fails;
        pend_cnt    <= keystream_q.size();
        byte_cnt    <= bytes_ok;
        shuffle_cnt <= shuffles;
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned RUN_BEATS  = 1800;
    localparam int unsigned LONG_HOLD  = 2000;
    localparam int unsigned LONG_RUNS  = 3;

    // bytes that bring the absorb position from zero to half the table
    localparam int unsigned PERM_HALF_BYTES = 64;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data
    logic [1:0] s_tuser  = 2'd0;    // [1:0] command
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte

    int unsigned fail_cnt, pend_cnt, byte_cnt, shuffle_cnt;
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;
    int unsigned bound_runs = 0;
    int unsigned cmd_seen [4];
    bit          hold_req   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    spritz_sponge_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sse_keystream_monitor u_mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_cnt    (fail_cnt),
        .pend_cnt    (pend_cnt),
        .byte_cnt    (byte_cnt),
        .shuffle_cnt (shuffle_cnt)
    );

    // send one beat; bursts of random length separated by random gaps
    task automatic push_beat(sse_pkg::cmd_t c, logic [7:0] d);
        int unsigned gap_len;
        if (burst_left == 0) begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_len > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        beats_sent++;
        cmd_seen[c]++;
    endtask

    // keystream bytes, a quarter of them with zero data
    task automatic drip_run(int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            push_beat(sse_pkg::CMD_DRIP,
                      ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
    endtask

    // absorb a short key or nonce, sometimes with a stop in it, then drip
    task automatic send_message(int unsigned drips);
        int unsigned n_abs, stop_at;
        n_abs   = $urandom_range(1, 6);
        stop_at = $urandom_range(0, 2 * n_abs);
        for (int unsigned k = 0; k < n_abs; k++) begin
            if (k == stop_at) begin
                push_beat(sse_pkg::CMD_STOP, 8'($urandom_range(0, 255)));
            end
            push_beat(sse_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
        end
        drip_run(drips);
    endtask

    // fill absorb position to its bound, then cross it by absorb or stop
    task automatic cross_bound();
        push_beat(sse_pkg::CMD_DRIP, 8'($urandom_range(0, 255)));
        repeat (PERM_HALF_BYTES) push_beat(sse_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) begin
            push_beat(sse_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
        end else begin
            push_beat(sse_pkg::CMD_STOP, 8'($urandom_range(0, 255)));
        end
        drip_run($urandom_range(3, 10));
        bound_runs++;
    endtask

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int unsigned mode, left, tick;
        mode = 0;
        left = 0;
        tick = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(32, 256);
                end
                left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 5) != 2);
                endcase
            end
        end
    end

    // stimulus
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // keystream straight from the reset state, nothing absorbed
        push_beat(sse_pkg::CMD_DRIP, 8'h00);
        push_beat(sse_pkg::CMD_DRIP, 8'hff);
        push_beat(sse_pkg::CMD_DRIP, 8'ha5);
        // nibble extremes, a stop, then a drip that has to shuffle
        push_beat(sse_pkg::CMD_ABSORB, 8'h00);
        push_beat(sse_pkg::CMD_ABSORB, 8'hff);
        push_beat(sse_pkg::CMD_ABSORB, 8'h5a);
        push_beat(sse_pkg::CMD_STOP, 8'h00);
        push_beat(sse_pkg::CMD_DRIP, 8'h00);
        push_beat(sse_pkg::CMD_DRIP, 8'h80);
        // reset command brings back the first keystream byte
        push_beat(sse_pkg::CMD_RESET, 8'hff);
        push_beat(sse_pkg::CMD_DRIP, 8'h00);
        push_beat(sse_pkg::CMD_DRIP, 8'h01);
        // stops alone still force a shuffle on the next drip
        push_beat(sse_pkg::CMD_STOP, 8'h00);
        push_beat(sse_pkg::CMD_STOP, 8'h3c);
        push_beat(sse_pkg::CMD_DRIP, 8'h7f);
        push_beat(sse_pkg::CMD_ABSORB, 8'h0f);
        push_beat(sse_pkg::CMD_ABSORB, 8'hf0);
        push_beat(sse_pkg::CMD_DRIP, 8'hff);
        push_beat(sse_pkg::CMD_DRIP, 8'h00);
        push_beat(sse_pkg::CMD_RESET, 8'h00);
        push_beat(sse_pkg::CMD_DRIP, 8'h00);

        // long stretch without reset so that the step wraps around
        for (int m = 0; m < 44; m++) begin
            send_message($urandom_range(4, 24));
            if (m == 8) begin
                // receiver holds off while drips keep coming
                hold_req = 1'b1;
                drip_run(40);
            end
        end

        // mixed traffic
        while (beats_sent < RUN_BEATS) begin
            case ($urandom_range(0, 9))
                0: begin
                    push_beat(sse_pkg::CMD_RESET, 8'($urandom_range(0, 255)));
                    drip_run($urandom_range(2, 10));
                end
                1: begin
                    if (bound_runs < LONG_RUNS) begin
                        cross_bound();
                    end else begin
                        drip_run($urandom_range(5, 30));
                    end
                end
                7, 8: drip_run($urandom_range(5, 30));
                9: begin
                    repeat ($urandom_range(1, 4)) begin
                        push_beat(sse_pkg::cmd_t'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)));
                    end
                end
                default: send_message($urandom_range(10, 40));
            endcase
        end
        s_tvalid <= 1'b0;

        // drain, then leave room for a trailing shuffle
        @(posedge aclk);
        while (pend_cnt != 0) @(posedge aclk);
        repeat (10000) @(posedge aclk);

        $display("run covered %0d beats: %0d resets, %0d absorbs, %0d stops, %0d drips",
                 beats_sent, cmd_seen[sse_pkg::CMD_RESET], cmd_seen[sse_pkg::CMD_ABSORB],
                 cmd_seen[sse_pkg::CMD_STOP], cmd_seen[sse_pkg::CMD_DRIP]);
        $display("%0d keystream bytes matched, %0d shuffles, %0d absorb bound crossings",
                 byte_cnt, shuffle_cnt, bound_runs);
        if (fail_cnt == 0 && pend_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
